// ===== hw/rtl/pixel_raster_op_unit_defines.svh =====
// Assertion macros shared by the pixel raster-op unit.
// Every check is sampled on aclk and is switched off while aresetn is low.
`ifndef PIXEL_RASTER_OP_UNIT_DEFINES_SVH
`define PIXEL_RASTER_OP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PROU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PROU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/prou_pkg.sv =====
package prou_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE     = 2'd2;

    localparam logic [15:0] RESET_SCREEN_WIDTH  = 16'd640;
    localparam logic [15:0] RESET_SCREEN_HEIGHT = 16'd480;
    localparam logic        RESET_FOUR_BYTE     = 1'b1;

    localparam int unsigned S_TDATA_W = 104;
    localparam int unsigned M_TDATA_W = 56;
    localparam int unsigned M_TUSER_W = 3;

    localparam logic [7:0] OP_COPY          = 8'd0;
    localparam logic [7:0] OP_OR            = 8'd1;
    localparam logic [7:0] OP_AND           = 8'd2;
    localparam logic [7:0] OP_XOR           = 8'd3;
    localparam logic [7:0] OP_NAND          = 8'd4;
    localparam logic [7:0] OP_CLR_RED_LSB   = 8'd10;
    localparam logic [7:0] OP_CLR_GREEN_LSB = 8'd11;
    localparam logic [7:0] OP_CLR_BLUE_LSB  = 8'd12;
    localparam logic [7:0] OP_HIGH_BIT      = 8'd20;
    localparam logic [7:0] OP_DROP_RED      = 8'd21;
    localparam logic [7:0] OP_LUMA_GREY     = 8'd22;
    localparam logic [7:0] OP_ALPHA_BLEND   = 8'd30;
    localparam logic [7:0] OP_INVERT        = 8'd31;
    localparam logic [7:0] OP_ADD_SAT       = 8'd32;
    localparam logic [7:0] OP_MULTIPLY      = 8'd33;
    localparam logic [7:0] OP_KEEP_DST      = 8'd34;
    localparam logic [7:0] OP_SRC_HALF      = 8'd35;
    localparam logic [7:0] OP_DST_HALF      = 8'd36;
    localparam logic [7:0] OP_MAX           = 8'd37;
    localparam logic [7:0] OP_MIN           = 8'd38;
    localparam logic [7:0] OP_NOT_DST       = 8'd39;
    localparam logic [7:0] OP_AVERAGE       = 8'd40;
    localparam logic [7:0] OP_DIFFERENCE    = 8'd41;
    localparam logic [7:0] OP_BRIGHTEN      = 8'd42;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    localparam logic [7:0] LSB_CLEAR_MASK = 8'hFE;
    localparam logic [7:0] HIGH_BIT_MASK  = 8'h80;
    localparam logic [7:0] CHAN_MAX       = 8'd255;
    localparam logic [8:0] BRIGHTEN_STEP  = 9'd64;

    localparam logic [14:0] LUMA_R_WEIGHT = 15'd30;
    localparam logic [14:0] LUMA_G_WEIGHT = 15'd59;
    localparam logic [14:0] LUMA_B_WEIGHT = 15'd11;
    // ceil(2^21 / 100); exact for sums below 43690, and the weighted sum stays below 25501.
    localparam logic [29:0] LUMA_RECIP    = 30'd20972;
    localparam int unsigned LUMA_SHIFT    = 21;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_CLIPPED = 2'd1,
        ST_BEYOND  = 2'd2
    } status_t;

    typedef struct packed {
        logic             clip;
        logic             fbp;
        logic [7:0]       op;
        logic [31:0]      src;
        logic [31:0]      dst;
        logic [17:0]      x_b;
        logic [15:0]      y;
        logic [17:0]      pitch;
        logic [2:0][15:0] prod_sd;
        logic [2:0][15:0] prod_sa;
        logic [2:0][15:0] prod_da;
        logic [14:0]      luma_sum;
    } stage1_t;

    typedef struct packed {
        logic            clip;
        logic            fbp;
        logic [7:0]      op;
        logic [31:0]     src;
        logic [31:0]     dst;
        logic [17:0]     x_b;
        logic [33:0]     row_prod;
        logic [2:0][7:0] blend_q;
        logic [2:0][7:0] mul_q;
        logic [29:0]     luma_mul;
    } stage2_t;

    typedef struct packed {
        status_t     status;
        logic [20:0] byte_offset;
        logic [31:0] new_color;
        logic        write_alpha;
    } result_t;

    // floor(p / 255) for p up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return t[15:8];
    endfunction

    function automatic logic [7:0] chan_op(input logic [7:0] op, input logic [7:0] s,
                                           input logic [7:0] d, input logic [1:0] idx,
                                           input logic [7:0] mul_q);
        logic [8:0] sum;
        logic [8:0] brt;
        logic [7:0] r;
        sum = {1'b0, s} + {1'b0, d};
        brt = {1'b0, d} + BRIGHTEN_STEP;
        case (op)
            OP_COPY:          r = s;
            OP_OR:            r = s | d;
            OP_AND:           r = s & d;
            OP_XOR:           r = s ^ d;
            OP_NAND:          r = ~(s & d);
            OP_CLR_RED_LSB:   r = (idx == CH_RED) ? (d & LSB_CLEAR_MASK) : d;
            OP_CLR_GREEN_LSB: r = (idx == CH_GREEN) ? (d & LSB_CLEAR_MASK) : d;
            OP_CLR_BLUE_LSB:  r = (idx == CH_BLUE) ? (d & LSB_CLEAR_MASK) : d;
            OP_HIGH_BIT:      r = d & HIGH_BIT_MASK;
            OP_DROP_RED:      r = (idx == CH_RED) ? 8'd0 : d;
            OP_INVERT:        r = CHAN_MAX - d;
            OP_ADD_SAT:       r = sum[8] ? CHAN_MAX : sum[7:0];
            OP_MULTIPLY:      r = mul_q;
            OP_SRC_HALF:      r = s >> 1;
            OP_DST_HALF:      r = d >> 1;
            OP_MAX:           r = (s > d) ? s : d;
            OP_MIN:           r = (s < d) ? s : d;
            OP_NOT_DST:       r = ~d;
            OP_AVERAGE:       r = sum[8:1];
            OP_DIFFERENCE:    r = (s > d) ? (s - d) : (d - s);
            OP_BRIGHTEN:      r = brt[8] ? CHAN_MAX : brt[7:0];
            default:          r = d;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/pixel_raster_op_unit.sv =====
// Pixel raster-op unit: the pixel write stage of a 2D drawing engine.
// The s_axis channel carries one pixel write per transaction: position, source colour,
// the destination pixel already read from the framebuffer, and a raster-op code.
// The m_axis channel returns one transaction per input: a status, the byte offset in the
// framebuffer, the new pixel and whether its alpha byte is to be stored.
// The cfg channel writes screen width, screen height and the pixel size; it is always
// ready; the user must write it only while no pixel is in flight (not enforced here).
// An input transaction passes the pipeline stages in order: products and clipping, then
// the row multiply and the divisions by 255 and 100, then the offset sum, buffer limit
// test and operation select into the output register.
// Throughput is one pixel per clock while the receiver does not stall m_axis.
// When the receiver stalls, a full stage holds its item and empty stages ahead of it
// still fill, so up to three transactions are taken before s_axis_tready falls.
// A synchronous low aresetn empties the pipeline and restores 640 by 480 at 32 bpp.
`include "pixel_raster_op_unit_defines.svh"

module pixel_raster_op_unit
    import prou_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 2097152
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x[15:0], pos_y[31:16], src_color[63:32], dst_color[95:64], op_code[103:96]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // byte_offset[20:0], new_color[52:21], zero fill [55:53]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // status[1:0], write_alpha[2]
    output logic [M_TUSER_W-1:0]  m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [15:0] screen_width_reg, screen_width_next;
    logic [15:0] screen_height_reg, screen_height_next;
    logic        four_byte_reg, four_byte_next;

    logic    v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    result_t out_reg, out_next;
    logic    en1, en2, en3;

    logic [15:0] in_x, in_y;
    logic [31:0] in_src, in_dst;
    logic [7:0]  in_op;
    logic [7:0]  alpha;

    assign cfg_ready = 1'b1;

    always_comb begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        four_byte_next     = four_byte_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_next = cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_next = cfg_data;
                CFG_FOUR_BYTE:     four_byte_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    assign en3 = !v3_reg || m_axis_tready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    assign v1_next = en1 ? s_axis_tvalid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;

    assign in_x   = s_axis_tdata[15:0];
    assign in_y   = s_axis_tdata[31:16];
    assign in_src = s_axis_tdata[63:32];
    assign in_dst = four_byte_reg ? s_axis_tdata[95:64] : {8'd0, s_axis_tdata[87:64]};
    assign in_op  = s_axis_tdata[103:96];
    assign alpha  = in_src[31:24];

    // Stage 1: clipping, pitch, and the 8 by 8 channel products.
    always_comb begin
        s1_next.clip  = (in_x >= screen_width_reg) || (in_y >= screen_height_reg);
        s1_next.fbp   = four_byte_reg;
        s1_next.op    = in_op;
        s1_next.src   = in_src;
        s1_next.dst   = in_dst;
        s1_next.y     = in_y;
        s1_next.x_b   = four_byte_reg ? {in_x, 2'b00} : ({1'b0, in_x, 1'b0} + {2'b00, in_x});
        s1_next.pitch = four_byte_reg ? {screen_width_reg, 2'b00}
                                      : ({1'b0, screen_width_reg, 1'b0}
                                         + {2'b00, screen_width_reg});
        for (int k = 0; k < 3; k++) begin
            s1_next.prod_sd[k] = 16'(in_src[8*k +: 8]) * 16'(in_dst[8*k +: 8]);
            s1_next.prod_sa[k] = 16'(in_src[8*k +: 8]) * 16'(alpha);
            s1_next.prod_da[k] = 16'(in_dst[8*k +: 8]) * 16'(CHAN_MAX - alpha);
        end
        s1_next.luma_sum = 15'(in_dst[23:16]) * LUMA_R_WEIGHT
                         + 15'(in_dst[15:8]) * LUMA_G_WEIGHT
                         + 15'(in_dst[7:0]) * LUMA_B_WEIGHT;
    end

    // Stage 2: row multiply, divisions by 255, and the luma reciprocal multiply.
    always_comb begin
        s2_next.clip     = s1_reg.clip;
        s2_next.fbp      = s1_reg.fbp;
        s2_next.op       = s1_reg.op;
        s2_next.src      = s1_reg.src;
        s2_next.dst      = s1_reg.dst;
        s2_next.x_b      = s1_reg.x_b;
        s2_next.row_prod = 34'(s1_reg.pitch) * 34'(s1_reg.y);
        for (int k = 0; k < 3; k++) begin
            s2_next.blend_q[k] = div255(s1_reg.prod_sa[k] + s1_reg.prod_da[k]);
            s2_next.mul_q[k]   = div255(s1_reg.prod_sd[k]);
        end
        s2_next.luma_mul = 30'(s1_reg.luma_sum) * LUMA_RECIP;
    end

    // Stage 3: offset, buffer limit and the operation select.
    always_comb begin
        logic [34:0] offset;
        logic [7:0]  luma;
        logic [31:0] color;
        offset = 35'(s2_reg.row_prod) + 35'(s2_reg.x_b);
        luma   = s2_reg.luma_mul[LUMA_SHIFT +: 8];
        color  = '0;
        for (int k = 0; k < 3; k++) begin
            if (s2_reg.op == OP_LUMA_GREY) begin
                color[8*k +: 8] = luma;
            end else if (s2_reg.op == OP_ALPHA_BLEND) begin
                color[8*k +: 8] = s2_reg.blend_q[k];
            end else begin
                color[8*k +: 8] = chan_op(s2_reg.op, s2_reg.src[8*k +: 8],
                                          s2_reg.dst[8*k +: 8], 2'(k), s2_reg.mul_q[k]);
            end
        end
        if (!s2_reg.fbp) begin
            color[31:24] = 8'd0;
        end else if ((s2_reg.op == OP_COPY) || (s2_reg.op == OP_SRC_HALF)) begin
            color[31:24] = s2_reg.src[31:24];
        end else begin
            color[31:24] = s2_reg.dst[31:24];
        end

        out_next = '0;
        if (s2_reg.clip) begin
            out_next.status = ST_CLIPPED;
        end else if (offset >= 35'(BUFFER_BYTES)) begin
            out_next.status = ST_BEYOND;
        end else begin
            out_next.status      = ST_WRITTEN;
            out_next.byte_offset = offset[20:0];
            out_next.new_color   = color;
            out_next.write_alpha = s2_reg.fbp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= RESET_SCREEN_WIDTH;
            screen_height_reg <= RESET_SCREEN_HEIGHT;
            four_byte_reg     <= RESET_FOUR_BYTE;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
        end else begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            four_byte_reg     <= four_byte_next;
            v1_reg            <= v1_next;
            v2_reg            <= v2_next;
            v3_reg            <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg <= s1_next;
        end
        if (en2) begin
            s2_reg <= s2_next;
        end
        if (en3) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {3'b000, out_reg.new_color, out_reg.byte_offset};
    assign m_axis_tuser  = {out_reg.write_alpha, out_reg.status};

    `PROU_ASSERT_NOW(a_reject_zeroes, v3_reg && (out_reg.status != ST_WRITTEN),
        (out_reg.new_color == 32'd0) && (out_reg.byte_offset == 21'd0) && !out_reg.write_alpha,
        "rejected pixel carries a non-zero result")
    `PROU_ASSERT_NOW(a_no_alpha_24bpp, v3_reg && !out_reg.write_alpha,
        out_reg.new_color[31:24] == 8'd0, "alpha byte set without an alpha write")
    `PROU_ASSERT_NEXT(a_stage2_holds, v2_reg && !en3, v2_reg,
        "stalled middle stage lost its item")
    `PROU_ASSERT_NOW(a_ready_only_when_full, !s_axis_tready,
        v1_reg && v2_reg && v3_reg && !m_axis_tready, "input stalled with room in the pipeline")

endmodule

// ===== dv/tb_pixel_raster_op_unit.sv =====
`timescale 1ns / 100ps

module tb_pixel_raster_op_unit;
    import prou_pkg::*;

    localparam int unsigned FRAME_BYTES  = 2097152;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned NUM_SETTINGS = 10;

    // Predicts each pixel write from the current screen settings and keeps the
    // outcomes that are still owed by the block, oldest first.
    class raster_op_scoreboard;
        logic [15:0] width  = RESET_SCREEN_WIDTH;
        logic [15:0] height = RESET_SCREEN_HEIGHT;
        logic        four_byte = RESET_FOUR_BYTE;
        result_t     expected_pixels[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned n_written;
        int unsigned n_clipped;
        int unsigned n_beyond;
        int unsigned n_three_byte;

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
            case (idx)
                CFG_SCREEN_WIDTH:  width = data;
                CFG_SCREEN_HEIGHT: height = data;
                CFG_FOUR_BYTE:     four_byte = data[0];
                default:           ;
            endcase
        endfunction

        function int unsigned outstanding();
            return expected_pixels.size();
        endfunction

        function result_t predict_pixel(input logic [15:0] x, input logic [15:0] y,
                                        input logic [31:0] src, input logic [31:0] dst,
                                        input logic [7:0] op);
            result_t         r;
            longint unsigned bpp;
            longint unsigned offset;
            int unsigned     s[4];
            int unsigned     d[4];
            int unsigned     n[4];
            int unsigned     luma;
            int unsigned     a;
            r = '0;
            r.status = ST_WRITTEN;
            if (x >= width || y >= height) begin
                r.status = ST_CLIPPED;
                return r;
            end
            bpp = four_byte ? 4 : 3;
            offset = width * bpp * y + x * bpp;
            if (offset >= FRAME_BYTES) begin
                r.status = ST_BEYOND;
                return r;
            end
            for (int k = 0; k < 4; k++) begin
                s[k] = (src >> (8 * k)) & 8'hFF;
                d[k] = (dst >> (8 * k)) & 8'hFF;
            end
            if (!four_byte)
                d[3] = 0;
            luma = (d[2] * 30 + d[1] * 59 + d[0] * 11) / 100;
            a = s[3];
            for (int k = 0; k < 3; k++) begin
                case (op)
                    OP_COPY:          n[k] = s[k];
                    OP_OR:            n[k] = s[k] | d[k];
                    OP_AND:           n[k] = s[k] & d[k];
                    OP_XOR:           n[k] = s[k] ^ d[k];
                    OP_NAND:          n[k] = ~(s[k] & d[k]) & 8'hFF;
                    OP_CLR_RED_LSB:   n[k] = (k == CH_RED) ? (d[k] & 8'hFE) : d[k];
                    OP_CLR_GREEN_LSB: n[k] = (k == CH_GREEN) ? (d[k] & 8'hFE) : d[k];
                    OP_CLR_BLUE_LSB:  n[k] = (k == CH_BLUE) ? (d[k] & 8'hFE) : d[k];
                    OP_HIGH_BIT:      n[k] = d[k] & 8'h80;
                    OP_DROP_RED:      n[k] = (k == CH_RED) ? 0 : d[k];
                    OP_LUMA_GREY:     n[k] = luma;
                    OP_ALPHA_BLEND:   n[k] = (s[k] * a + d[k] * (255 - a)) / 255;
                    OP_INVERT:        n[k] = 255 - d[k];
                    OP_ADD_SAT:       n[k] = (s[k] + d[k] > 255) ? 255 : s[k] + d[k];
                    OP_MULTIPLY:      n[k] = (s[k] * d[k]) / 255;
                    OP_SRC_HALF:      n[k] = s[k] >> 1;
                    OP_DST_HALF:      n[k] = d[k] >> 1;
                    OP_MAX:           n[k] = (s[k] > d[k]) ? s[k] : d[k];
                    OP_MIN:           n[k] = (s[k] < d[k]) ? s[k] : d[k];
                    OP_NOT_DST:       n[k] = ~d[k] & 8'hFF;
                    OP_AVERAGE:       n[k] = (s[k] + d[k]) >> 1;
                    OP_DIFFERENCE:    n[k] = (s[k] > d[k]) ? s[k] - d[k] : d[k] - s[k];
                    OP_BRIGHTEN:      n[k] = (d[k] + 64 > 255) ? 255 : d[k] + 64;
                    default:          n[k] = d[k];
                endcase
            end
            n[3] = (op == OP_COPY || op == OP_SRC_HALF) ? s[3] : d[3];
            if (!four_byte)
                n[3] = 0;
            r.byte_offset = offset[20:0];
            r.new_color = {n[3][7:0], n[2][7:0], n[1][7:0], n[0][7:0]};
            r.write_alpha = four_byte;
            return r;
        endfunction

        function void note_pixel(input logic [15:0] x, input logic [15:0] y,
                                 input logic [31:0] src, input logic [31:0] dst,
                                 input logic [7:0] op);
            result_t r;
            r = predict_pixel(x, y, src, dst, op);
            case (r.status)
                ST_CLIPPED: n_clipped++;
                ST_BEYOND:  n_beyond++;
                default:    n_written++;
            endcase
            if (!four_byte)
                n_three_byte++;
            expected_pixels.push_back(r);
        endfunction

        function void check_result(input result_t got, input logic [2:0] pad);
            result_t want;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing outstanding: %s %0d offset %h colour %h",
                             $realtime, "status", got.status, got.byte_offset, got.new_color);
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (got.status !== want.status || got.byte_offset !== want.byte_offset ||
                    got.new_color !== want.new_color || got.write_alpha !== want.write_alpha ||
                    pad !== 3'b000) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: pixel %0d mismatch: expected status %0d offset %h colour %h%s",
                             $realtime, checked, want.status, want.byte_offset, want.new_color,
                             ",");
                    $display("    expected alpha %b pad 0, got status %0d offset %h colour %h",
                             want.write_alpha, got.status, got.byte_offset, got.new_color);
                    $display("    got alpha %b pad %h", got.write_alpha, pad);
                end
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // pos_x[15:0], pos_y[31:16], src_color[63:32], dst_color[95:64], op_code[103:96]
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // byte_offset[20:0], new_color[52:21], zero fill [55:53]
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // status[1:0], write_alpha[2]
    logic [M_TUSER_W-1:0]  m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    raster_op_scoreboard sb;
    result_t             seen_pixel;
    bit                  tx_idle_en = 1'b1;
    bit                  rx_idle_en = 1'b1;
    int unsigned         rx_hold = 0;
    int unsigned         idle_cycles = 0;
    int unsigned         settings_used;

    logic [7:0] known_ops [24] = '{
        OP_COPY, OP_OR, OP_AND, OP_XOR, OP_NAND, OP_CLR_RED_LSB, OP_CLR_GREEN_LSB,
        OP_CLR_BLUE_LSB, OP_HIGH_BIT, OP_DROP_RED, OP_LUMA_GREY, OP_ALPHA_BLEND, OP_INVERT,
        OP_ADD_SAT, OP_MULTIPLY, OP_KEEP_DST, OP_SRC_HALF, OP_DST_HALF, OP_MAX, OP_MIN,
        OP_NOT_DST, OP_AVERAGE, OP_DIFFERENCE, OP_BRIGHTEN
    };

    // Screen settings per phase; the first phase runs on the reset values.
    int unsigned screen_w [NUM_SETTINGS] = '{640, 65535, 1, 800, 1024, 65535, 0, 7, 320, 1920};
    int unsigned screen_h [NUM_SETTINGS] = '{480, 65535, 1, 600, 512, 65535, 5, 0, 240, 1080};
    bit          screen_b [NUM_SETTINGS] = '{1, 1, 0, 0, 1, 0, 1, 0, 1, 1};
    int unsigned phase_items [NUM_SETTINGS] = '{200, 200, 120, 200, 200, 200, 40, 40, 200, 250};

    pixel_raster_op_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_colour();
        logic [31:0] c;
        int unsigned r;
        r = $urandom_range(0, 99);
        c = $urandom;
        if (r < 10)
            c = '0;
        else if (r < 20)
            c = '1;
        else if (r < 35)
            c[31:24] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return c;
    endfunction

    task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
                              input logic [31:0] src, input logic [31:0] dst,
                              input logic [7:0] op);
        @(negedge aclk);
        s_axis_tdata = {op, dst, src, y, x};
        s_axis_tvalid = 1'b1;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        sb.note_pixel(x, y, src, dst, op);
    endtask

    task automatic sender_gap();
        int unsigned gap;
        gap = tx_idle_en ? gap_cycles() : 0;
        if (gap != 0) begin
            @(negedge aclk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Holds the sender off until every owed result has been taken.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do
            @(posedge aclk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic write_screen(input int unsigned w, input int unsigned h, input bit b);
        write_register(CFG_SCREEN_WIDTH, w[15:0]);
        write_register(CFG_SCREEN_HEIGHT, h[15:0]);
        // Only bit 0 of the pixel size register is meaningful.
        write_register(CFG_FOUR_BYTE, {15'($urandom), b});
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold--;
        end else if (rx_idle_en && $urandom_range(0, 99) < 30) begin
            m_axis_tready <= 1'b0;
            rx_hold = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2) :
                                                     $urandom_range(10, 60);
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold = $urandom_range(0, 6);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen_pixel.status = status_t'(m_axis_tuser[1:0]);
            seen_pixel.write_alpha = m_axis_tuser[2];
            seen_pixel.byte_offset = m_axis_tdata[20:0];
            seen_pixel.new_color = m_axis_tdata[52:21];
            sb.check_result(seen_pixel, m_axis_tdata[55:53]);
        end
    end

    // Any transaction on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("tb_pixel_raster_op_unit: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [15:0]     px;
        logic [15:0]     py;
        logic [31:0]     src;
        logic [31:0]     dst;
        logic [7:0]      op;
        int unsigned     w;
        int unsigned     h;
        int unsigned     pick;
        longint unsigned bpp;
        longint unsigned pitch;
        longint unsigned row_cap;
        longint unsigned rem;
        longint unsigned edge_x;
        longint unsigned edge_y;

        sb = new();
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SCREEN_WIDTH;
        cfg_data = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Every operation once on the reset screen, with the corners and the clip
        // edges on the first items and the colour extremes rotating through.
        for (int i = 0; i < 24; i++) begin
            case (i)
                0:       begin px = 0;     py = 0;     end
                1:       begin px = 639;   py = 479;   end
                2:       begin px = 640;   py = 0;     end
                3:       begin px = 0;     py = 480;   end
                4:       begin px = 16'hFFFF; py = 16'hFFFF; end
                default: begin
                    px = 16'($urandom_range(0, 639));
                    py = 16'($urandom_range(0, 479));
                end
            endcase
            case (i % 4)
                0:       begin src = '1; dst = '0; end
                1:       begin src = '0; dst = '1; end
                2:       begin src = {8'h00, 24'($urandom)}; dst = $urandom; end
                default: begin src = $urandom; dst = $urandom; end
            endcase
            send_pixel(px, py, src, dst, known_ops[i]);
        end
        // Codes outside the operation list leave the destination as it is.
        send_pixel(10, 10, $urandom, $urandom, 8'hFF);
        send_pixel(11, 10, $urandom, $urandom, 8'd5);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            w = screen_w[p];
            h = screen_h[p];
            if (p != 0) begin
                drain_pipeline();
                write_screen(w, h, screen_b[p]);
            end
            settings_used++;
            tx_idle_en = (p % 3 != 1);
            rx_idle_en = (p % 3 != 1);
            bpp = screen_b[p] ? 4 : 3;
            pitch = w * bpp;

            if (w != 0 && h != 0) begin
                send_pixel(16'(w - 1), 16'(h - 1), pick_colour(), pick_colour(), known_ops[p]);
                send_pixel(16'(w), 16'(h - 1), pick_colour(), pick_colour(), known_ops[p + 1]);
                // The last pixel that fits the buffer and the first one that does not.
                edge_y = FRAME_BYTES / pitch;
                if (edge_y < h) begin
                    rem = FRAME_BYTES - pitch * edge_y;
                    edge_x = (rem + bpp - 1) / bpp;
                    if (edge_x > 0 && edge_x < w) begin
                        send_pixel(16'(edge_x - 1), 16'(edge_y), pick_colour(), pick_colour(),
                                   OP_COPY);
                        send_pixel(16'(edge_x), 16'(edge_y), pick_colour(), pick_colour(),
                                   OP_AVERAGE);
                    end
                end
            end

            for (int n = 0; n < phase_items[p]; n++) begin
                pick = $urandom_range(0, 99);
                if (w == 0 || h == 0 || pick < 10) begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end else if (pick < 15) begin
                    px = 16'(w - $urandom_range(0, 1));
                    py = 16'($urandom_range(0, h - 1));
                end else if (pick < 20) begin
                    px = 16'($urandom_range(0, w - 1));
                    py = 16'(h - $urandom_range(0, 1));
                end else begin
                    // Keep most rows inside the buffer so that the colour path is exercised.
                    row_cap = FRAME_BYTES / pitch;
                    if (row_cap > h - 1 || $urandom_range(0, 99) < 20)
                        row_cap = h - 1;
                    px = 16'($urandom_range(0, w - 1));
                    py = 16'($urandom_range(0, int'(row_cap)));
                end
                op = ($urandom_range(0, 99) < 75) ? known_ops[$urandom_range(0, 23)] :
                                                    8'($urandom);
                src = pick_colour();
                dst = pick_colour();
                send_pixel(px, py, src, dst, op);
                sender_gap();
                if (p % 2 == 0 && n == phase_items[p] / 2)
                    drain_pipeline();
            end
        end

        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Checked %0d pixel writes over %0d screen settings, %0d of them at 24 bpp.",
                 sb.checked, settings_used, sb.n_three_byte);
        $display("Outcomes: %0d written, %0d clipped, %0d past the buffer end; %0d mismatches.",
                 sb.n_written, sb.n_clipped, sb.n_beyond, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb_pixel_raster_op_unit: PASS");
        end else begin
            $display("tb_pixel_raster_op_unit: FAIL");
        end
        $finish;
    end

endmodule
